// ----- hdl/npd_pkg.sv -----
package npd_pkg;

	localparam int MAX_TARGETS = 256;
	localparam int ADDR_W      = $clog2(MAX_TARGETS);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int COORD_W     = 16;
	localparam int SQ_W        = 2 * COORD_W;
	localparam int SUM_W       = SQ_W + 1;
	localparam int ROOT_W      = (SUM_W + 1) / 2;
	localparam int RAD_W       = 2 * ROOT_W;
	localparam int REM_W       = ROOT_W + 3;
	localparam int STEP_W      = $clog2(ROOT_W + 1);
	localparam int OP_W        = 2;
	localparam int IN_DATA_W   = 2 * COORD_W;
	localparam int OUT_DATA_W  = ((ROOT_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2
	} opcode_t;

	// x sits in the low half, matching the tdata layout
	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

endpackage

// ----- hdl/npd_store.sv -----
module npd_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [npd_pkg::ADDR_W-1:0]    wr_addr,
	input  npd_pkg::point_t               wr_point,
	input  npd_pkg::rd_req_t              rd,
	output npd_pkg::point_t               rd_point,
	output logic                          rd_valid
);
	import npd_pkg::*;

	point_t mem_q [MAX_TARGETS];
	point_t rd_point_q;
	logic   rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_point;
		end
		if (rd.en) begin
			rd_point_q <= mem_q[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= rd.en;
		end
	end

	assign rd_point = rd_point_q;
	assign rd_valid = rd_valid_q;

endmodule

// ----- hdl/npd_dist.sv -----
module npd_dist (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        in_valid,
	input  npd_pkg::point_t             tgt,
	input  npd_pkg::point_t             qry,
	output logic [npd_pkg::SUM_W-1:0]   best,
	output logic                        busy
);
	import npd_pkg::*;

	logic signed [COORD_W:0] diff_x, diff_y;
	logic [COORD_W-1:0]      abs_x, abs_y;
	logic [COORD_W-1:0]      dx_s2, dy_s2;
	logic                    v_s2;
	logic [SQ_W-1:0]         sqx_s3, sqy_s3;
	logic                    v_s3;
	logic [SUM_W-1:0]        sum;
	logic [SUM_W-1:0]        best_q;
	logic                    first_q;

	always_comb begin
		diff_x = {qry.x[COORD_W-1], qry.x} - {tgt.x[COORD_W-1], tgt.x};
		diff_y = {qry.y[COORD_W-1], qry.y} - {tgt.y[COORD_W-1], tgt.y};
		abs_x  = diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
		abs_y  = diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
		sum    = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	end

	always_ff @(posedge clk) begin
		dx_s2  <= abs_x;
		dy_s2  <= abs_y;
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			best_q  <= '0;
			first_q <= 1'b1;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			if (start) begin
				best_q  <= '0;
				first_q <= 1'b1;
			end else if (v_s3) begin
				// keep the smaller squared distance
				if (first_q || sum < best_q) begin
					best_q <= sum;
				end
				first_q <= 1'b0;
			end
		end
	end

	assign best = best_q;
	assign busy = in_valid | v_s2 | v_s3;

endmodule

// ----- hdl/npd_isqrt.sv -----
module npd_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [npd_pkg::SUM_W-1:0]   radicand,
	output logic [npd_pkg::ROOT_W-1:0]  root,
	output logic                        done
);
	import npd_pkg::*;

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  cur;
	logic [REM_W-1:0]  trial;
	logic              ge;

	// one result bit per cycle, two radicand bits shifted in each step
	always_comb begin
		cur   = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial = {1'b0, root_q, 2'b01};
		ge    = cur >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rad_q  <= {{(RAD_W-SUM_W){1'b0}}, radicand};
			rem_q  <= '0;
			root_q <= '0;
			step_q <= STEP_W'(ROOT_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? cur - trial : cur;
			root_q <= {root_q[ROOT_W-2:0], ge};
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ----- hdl/nearest_point_distance.sv -----
// Clear and load beats are accepted in ST_IDLE, so s_axis_tready stays high after them.
// A query is accepted, then the stored targets stream one per cycle through the store
// read and the distance pipeline, the pipeline drains, the bit-serial square root
// starts and runs, and the root is held in ST_ROOT until the output register is free.
// s_axis_tready stays low from the accepting edge until the result is registered.
// Reset (arst_n low) empties the store and drops any pending result.
module nearest_point_distance (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [npd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // coord_x, coord_y
	input  logic [npd_pkg::OP_W-1:0]           s_axis_tuser,  // opcode
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [npd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // distance, zero pad
	output logic                               m_axis_tuser,  // empty_res
	output logic                               m_axis_tlast
);
	import npd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ROOT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	point_t            qry_q;
	logic              last_q;
	logic              empty_q;
	logic              m_valid_q;
	logic [ROOT_W-1:0] dist_q;
	logic              m_empty_q;
	logic              m_last_q;

	opcode_t           op;
	logic              accept;
	logic              not_full;
	rd_req_t           rd;
	point_t            tgt;
	logic              tgt_valid;
	logic [SUM_W-1:0]  best;
	logic              dist_busy;
	logic              scan_done;
	logic [ROOT_W-1:0] root;
	logic              root_done;
	logic              out_free;
	logic              emit;

	always_comb begin
		op        = opcode_t'(s_axis_tuser);
		accept    = s_axis_tvalid && s_axis_tready;
		not_full  = count_q != CNT_W'(MAX_TARGETS);
		rd.en     = (state_q == ST_SCAN) && (idx_q != count_q);
		rd.addr   = idx_q[ADDR_W-1:0];
		scan_done = (state_q == ST_SCAN) && !rd.en && !dist_busy;
		out_free  = !m_valid_q || m_axis_tready;
		emit      = (state_q == ST_ROOT) && root_done && out_free;
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	npd_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && op == OP_LOAD && not_full),
		.wr_addr  (count_q[ADDR_W-1:0]),
		.wr_point (point_t'(s_axis_tdata)),
		.rd       (rd),
		.rd_point (tgt),
		.rd_valid (tgt_valid)
	);

	npd_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && op == OP_QUERY),
		.in_valid (tgt_valid),
		.tgt      (tgt),
		.qry      (qry_q),
		.best     (best),
		.busy     (dist_busy)
	);

	npd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_done),
		.radicand (best),
		.root     (root),
		.done     (root_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			qry_q     <= '0;
			last_q    <= 1'b0;
			empty_q   <= 1'b0;
			m_valid_q <= 1'b0;
			dist_q    <= '0;
			m_empty_q <= 1'b0;
			m_last_q  <= 1'b0;
		end else begin
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_CLEAR: count_q <= '0;
							OP_LOAD: begin
								// drop loads once the store is full
								if (not_full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_QUERY: begin
								qry_q   <= point_t'(s_axis_tdata);
								last_q  <= s_axis_tlast;
								empty_q <= (count_q == '0);
								idx_q   <= '0;
								state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (rd.en) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (scan_done) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					// hold the root until the output register frees up
					if (emit) begin
						dist_q    <= root;
						m_empty_q <= empty_q;
						m_last_q  <= last_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-ROOT_W){1'b0}}, dist_q};
	assign m_axis_tuser  = m_empty_q;
	assign m_axis_tlast  = m_last_q;

endmodule
